// ----- hdl/prpi_pkg.sv -----
// Package with shared constants for the PageRank block.
package prpi_pkg;
  localparam int unsigned MaxPagesDefault = 64;
  localparam int unsigned MaxEdgesDefault = 256;
  localparam int unsigned RankFracBitsDefault = 16;
  localparam int unsigned PageW = 6;
  localparam int unsigned IterW = 10;
  localparam logic [IterW-1:0] IterReset = 10'd1;
endpackage

// ----- hdl/prpi_if.sv -----
// Valid/ready channel interfaces for edges and ranks.
interface prpi_edge_if;
  logic valid;
  logic ready;
  logic [prpi_pkg::PageW-1:0] source_page;
  logic [prpi_pkg::PageW-1:0] target_page;
  logic final_edge;
  modport source (output valid, source_page, target_page, final_edge, input ready);
  modport sink (input valid, source_page, target_page, final_edge, output ready);
endinterface

interface prpi_rank_if #(parameter int unsigned RankW = prpi_pkg::RankFracBitsDefault + 1);
  logic valid;
  logic ready;
  logic [prpi_pkg::PageW-1:0] page_index;
  logic [RankW-1:0] page_rank;
  logic final_rank;
  modport source (output valid, page_index, page_rank, final_rank, input ready);
  modport sink (input valid, page_index, page_rank, final_rank, output ready);
endinterface

// ----- hdl/prpi_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module prpi_div #(
  parameter int unsigned NumW = 17,
  parameter int unsigned DenW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW:0]   trial;

  // One shift and subtract step per cycle.
  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ----- hdl/pagerank_power_iteration_top.sv -----
// Top level: edge store, rank tables and the sequencer that runs power iterations.
// Edges are taken one per cycle while idle; a non-final edge causes no result and no edge
// is taken during a run. A run counts targets (with none it ends there), finds out-degrees,
// divides for the start rank and seeds ranks; each round clears next ranks, divides and adds
// per stored edge and copies ranks back; then ranks leave page by page as the sink takes them.
// Reset clears flags, counts and the sequencer; the tables are cleared or written in each run.
module pagerank_power_iteration_top #(
  parameter int unsigned MAX_PAGES = prpi_pkg::MaxPagesDefault,
  parameter int unsigned MAX_EDGES = prpi_pkg::MaxEdgesDefault,
  parameter int unsigned RANK_FRAC_BITS = prpi_pkg::RankFracBitsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  input logic cfg_we_i,
  input logic [prpi_pkg::IterW-1:0] cfg_wdata_i,
  prpi_edge_if.sink edge_in,
  prpi_rank_if.source rank_out
);
  localparam int unsigned PageW = prpi_pkg::PageW;
  localparam int unsigned RankW = RANK_FRAC_BITS + 1;
  localparam int unsigned PIdxW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned ECntW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EIdxW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned DenW = ECntW;
  localparam int unsigned PCntW = $clog2(MAX_PAGES + 1);
  localparam int unsigned IterW = prpi_pkg::IterW;
  localparam logic [RankW-1:0] RankOne = RankW'(1) << RANK_FRAC_BITS;

  typedef enum logic [4:0] {
    StLoad, StCount, StDegRd, StDegAddr, StDegInc, StInitDiv, StInitWait, StInitSet,
    StRndClr, StEdgeRd, StEdgeFetch, StEdgeDiv, StEdgeWait, StEdgeAdd, StCopyRd,
    StCopyWr, StEmitRd, StEmitWr, StClear
  } state_e;

  state_e state_q;
  logic [IterW-1:0] iters_q;
  logic [ECntW-1:0] etotal_q;
  logic [MAX_PAGES-1:0] is_tgt_q, is_src_q;
  logic [2*PageW-1:0] estore [MAX_EDGES];
  logic [DenW-1:0] outdeg [MAX_PAGES];
  logic [RankW-1:0] rnow [MAX_PAGES];
  logic [RankW-1:0] rnext [MAX_PAGES];
  logic [2*PageW-1:0] erd_q;
  logic [DenW-1:0] odeg_q;
  logic [RankW-1:0] rnow_rd_q, rnext_rd_q;
  logic [PCntW-1:0] pcnt_q;
  logic [PCntW-1:0] tgts_q;
  logic [ECntW-1:0] ecnt_q;
  logic [IterW-1:0] rnd_q;
  logic [RankW-1:0] term_q, init_q;
  logic out_valid_q;
  logic [PageW-1:0] out_idx_q;
  logic [RankW-1:0] out_rank_q;
  logic out_last_q;
  logic wide_q;

  logic div_start, div_done;
  logic [RankW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den;

  logic [PageW-1:0] in_src, in_dst, e_src, e_dst;
  logic [PIdxW-1:0] pi, e_si, e_di, in_si, in_di, rnow_addr, rnext_addr;
  logic edge_ok, accept, emit_sel, more_emit, emit_room, out_launch;
  logic [RankW:0] sum;

  assign in_src = edge_in.source_page;
  assign in_dst = edge_in.target_page;
  assign in_si = PIdxW'(in_src);
  assign in_di = PIdxW'(in_dst);
  assign e_src = erd_q[2*PageW-1:PageW];
  assign e_dst = erd_q[PageW-1:0];
  assign e_si = PIdxW'(e_src);
  assign e_di = PIdxW'(e_dst);
  assign pi = pcnt_q[PIdxW-1:0];
  assign edge_in.ready = (state_q == StLoad);
  assign accept = edge_in.valid && edge_in.ready;
  assign edge_ok = (etotal_q < ECntW'(MAX_EDGES)) && (32'(in_src) < MAX_PAGES)
                   && (32'(in_dst) < MAX_PAGES);
  assign sum = {1'b0, rnext_rd_q} + {1'b0, term_q};
  assign emit_sel = is_tgt_q[pi] || (wide_q && is_src_q[pi]);
  assign emit_room = !out_valid_q || rank_out.ready;
  assign out_launch = (state_q == StEmitWr) && emit_room && emit_sel;

  // Read addresses: the page counter (rnow: reporting, rnext: copying), else the current edge.
  assign rnow_addr = (state_q == StEmitRd || state_q == StEmitWr) ? pi : e_si;
  assign rnext_addr = (state_q == StCopyRd || state_q == StCopyWr) ? pi : e_di;

  // Output beat registers.
  assign rank_out.valid = out_valid_q;
  assign rank_out.page_index = out_idx_q;
  assign rank_out.page_rank = out_rank_q;
  assign rank_out.final_rank = out_last_q;

  // Remaining reportable pages above the current one.
  always_comb begin
    more_emit = 1'b0;
    for (int p = 0; p < MAX_PAGES; p++) begin
      if (p > int'(pcnt_q) && (is_tgt_q[p] || (wide_q && is_src_q[p]))) more_emit = 1'b1;
    end
  end

  // Divider operands depend on the phase.
  always_comb begin
    div_start = 1'b0;
    div_num = RankOne;
    div_den = DenW'(tgts_q);
    case (state_q)
      StInitDiv: div_start = 1'b1;
      StEdgeDiv: begin
        div_start = 1'b1;
        div_num = rnow_rd_q;
        div_den = odeg_q;
      end
      default: ;
    endcase
  end

  prpi_div #(.NumW(RankW), .DenW(DenW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  // Edge store, out-degree and rank tables, each read through a register.
  always_ff @(posedge clk_i) begin
    if (accept && edge_ok) estore[etotal_q[EIdxW-1:0]] <= {in_src, in_dst};
    erd_q <= estore[ecnt_q[EIdxW-1:0]];
    odeg_q <= outdeg[e_si];
    rnow_rd_q <= rnow[rnow_addr];
    rnext_rd_q <= rnext[rnext_addr];
    case (state_q)
      StCount: outdeg[pi] <= '0;
      StDegInc: outdeg[e_si] <= odeg_q + 1'b1;
      StInitSet: rnow[pi] <= is_tgt_q[pi] ? init_q : '0;
      StRndClr: rnext[pi] <= '0;
      StEdgeAdd: rnext[e_di] <= (sum > {1'b0, RankOne}) ? RankOne : sum[RankW-1:0];
      StCopyWr: if (is_tgt_q[pi]) rnow[pi] <= rnext_rd_q;
      default: ;
    endcase
  end

  // Sequencer with control and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      iters_q <= prpi_pkg::IterReset;
      etotal_q <= '0;
      is_tgt_q <= '0;
      is_src_q <= '0;
      pcnt_q <= '0;
      tgts_q <= '0;
      ecnt_q <= '0;
      rnd_q <= '0;
      out_valid_q <= 1'b0;
      out_last_q <= 1'b0;
      wide_q <= 1'b0;
      term_q <= '0;
      init_q <= '0;
      out_idx_q <= '0;
      out_rank_q <= '0;
    end else begin
      if (cfg_we_i) iters_q <= cfg_wdata_i;
      if (out_launch) out_valid_q <= 1'b1;
      else if (rank_out.ready) out_valid_q <= 1'b0;
      case (state_q)
        StLoad: if (accept) begin
          if (edge_ok) begin
            etotal_q <= etotal_q + 1'b1;
            is_src_q[in_si] <= 1'b1;
            is_tgt_q[in_di] <= 1'b1;
          end
          if (edge_in.final_edge) begin
            pcnt_q <= '0;
            tgts_q <= '0;
            wide_q <= (iters_q >= IterW'(2));
            rnd_q <= (iters_q >= IterW'(2)) ? iters_q - 1'b1 : '0;
            state_q <= StCount;
          end
        end
        // Count targets and clear the out-degree table.
        StCount: begin
          tgts_q <= tgts_q + PCntW'(is_tgt_q[pi]);
          if (32'(pcnt_q) == MAX_PAGES - 1) begin
            pcnt_q <= '0;
            ecnt_q <= '0;
            state_q <= (is_tgt_q == '0) ? StClear : StDegRd;
          end else pcnt_q <= pcnt_q + 1'b1;
        end
        // Out-degree pass over the stored edges.
        StDegRd: state_q <= (ecnt_q == etotal_q) ? StInitDiv : StDegAddr;
        StDegAddr: state_q <= StDegInc;
        StDegInc: begin
          ecnt_q <= ecnt_q + 1'b1;
          state_q <= StDegRd;
        end
        StInitDiv: state_q <= StInitWait;
        StInitWait: if (div_done) begin
          init_q <= div_quot;
          state_q <= StInitSet;
        end
        StInitSet: begin
          if (32'(pcnt_q) == MAX_PAGES - 1) begin
            pcnt_q <= '0;
            state_q <= (rnd_q == '0) ? StEmitRd : StRndClr;
          end else pcnt_q <= pcnt_q + 1'b1;
        end
        StRndClr: begin
          if (32'(pcnt_q) == MAX_PAGES - 1) begin
            pcnt_q <= '0;
            ecnt_q <= '0;
            state_q <= StEdgeRd;
          end else pcnt_q <= pcnt_q + 1'b1;
        end
        StEdgeRd: state_q <= (ecnt_q == etotal_q) ? StCopyRd : StEdgeFetch;
        StEdgeFetch: state_q <= StEdgeDiv;
        StEdgeDiv: state_q <= StEdgeWait;
        StEdgeWait: if (div_done) begin
          term_q <= div_quot;
          state_q <= StEdgeAdd;
        end
        StEdgeAdd: begin
          ecnt_q <= ecnt_q + 1'b1;
          state_q <= StEdgeRd;
        end
        StCopyRd: state_q <= StCopyWr;
        StCopyWr: begin
          if (32'(pcnt_q) == MAX_PAGES - 1) begin
            pcnt_q <= '0;
            rnd_q <= rnd_q - 1'b1;
            state_q <= (rnd_q == IterW'(1)) ? StEmitRd : StRndClr;
          end else begin
            pcnt_q <= pcnt_q + 1'b1;
            state_q <= StCopyRd;
          end
        end
        StEmitRd: state_q <= StEmitWr;
        StEmitWr: if (emit_room) begin
          if (emit_sel) begin
            out_idx_q <= PageW'(pcnt_q);
            out_rank_q <= is_tgt_q[pi] ? rnow_rd_q : '0;
            out_last_q <= !more_emit;
          end
          if (32'(pcnt_q) == MAX_PAGES - 1) begin
            pcnt_q <= '0;
            state_q <= StClear;
          end else begin
            pcnt_q <= pcnt_q + 1'b1;
            state_q <= StEmitRd;
          end
        end
        StClear: begin
          etotal_q <= '0;
          is_tgt_q <= '0;
          is_src_q <= '0;
          state_q <= StLoad;
        end
        default: state_q <= StLoad;
      endcase
    end
  end
endmodule
